// ===== rtl/drbh_pkg.sv =====
package drbh_pkg;

    localparam int DEF_MAX_CLIENTS = 8;
    localparam int DEF_RING_DEPTH  = 64;
    localparam int CNT_W           = 16;
    localparam int CL_W            = 4;
    localparam int CFG_IDX_W       = 4;

    // Input operation codes
    localparam logic [2:0] OP_POST_TX   = 3'd0;
    localparam logic [2:0] OP_GIVE_RX   = 3'd1;
    localparam logic [2:0] OP_TAKE_RX   = 3'd2;
    localparam logic [2:0] OP_TAKE_TXD  = 3'd3;
    localparam logic [2:0] OP_FORWARD   = 3'd4;

    // Classified command kinds
    localparam logic [2:0] KIND_POST_TX  = 3'd0;
    localparam logic [2:0] KIND_GIVE_RX  = 3'd1;
    localparam logic [2:0] KIND_TAKE_RX  = 3'd2;
    localparam logic [2:0] KIND_TAKE_TXD = 3'd3;
    localparam logic [2:0] KIND_FORWARD  = 3'd4;
    localparam logic [2:0] KIND_BAD      = 3'd5;

    // Ring kinds within a client
    localparam logic [1:0] RK_TX_PEND = 2'd0;
    localparam logic [1:0] RK_TX_DONE = 2'd1;
    localparam logic [1:0] RK_RX_FREE = 2'd2;
    localparam logic [1:0] RK_RX_FILL = 2'd3;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOPEND   = 3'd3;
    localparam logic [2:0] ST_NORX     = 3'd4;
    localparam logic [2:0] ST_RXFULL   = 3'd5;
    localparam logic [2:0] ST_BADCL    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 4'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  client;
        logic [31:0] offset;
        logic [15:0] length;
    } drbh_cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [31:0] soff;
        logic [31:0] doff;
        logic [15:0] len;
        logic        any;
        logic        last;
    } drbh_res_t;

endpackage

// ===== rtl/drbh_front.sv =====
module drbh_front
    import drbh_pkg::*;
(
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [2:0]      s_operation,
    input  logic [2:0]      s_client,
    input  logic [31:0]     s_buffer_offset,
    input  logic [15:0]     s_frame_length,
    input  logic [CL_W-1:0] n_clients,
    input  logic            q_full,
    output logic            q_wr,
    output drbh_cmd_t       q_cmd
);

    logic op_known;
    logic bad_client;

    assign s_ready    = !q_full;
    assign op_known   = (s_operation == OP_POST_TX) || (s_operation == OP_GIVE_RX) ||
                        (s_operation == OP_TAKE_RX) || (s_operation == OP_TAKE_TXD) ||
                        (s_operation == OP_FORWARD);
    assign bad_client = (s_operation != OP_FORWARD) && ({1'b0, s_client} >= n_clients);

    // drop undefined operations: they produce no result
    assign q_wr = s_valid && s_ready && op_known;

    always_comb begin
        q_cmd.client = s_client;
        q_cmd.offset = s_buffer_offset;
        q_cmd.length = s_frame_length;
        case (s_operation)
            OP_POST_TX:  q_cmd.kind = KIND_POST_TX;
            OP_GIVE_RX:  q_cmd.kind = KIND_GIVE_RX;
            OP_TAKE_RX:  q_cmd.kind = KIND_TAKE_RX;
            OP_TAKE_TXD: q_cmd.kind = KIND_TAKE_TXD;
            OP_FORWARD:  q_cmd.kind = KIND_FORWARD;
            default:     q_cmd.kind = KIND_BAD;
        endcase
        if (bad_client) begin
            q_cmd.kind = KIND_BAD;
        end
    end

endmodule

// ===== rtl/drbh_cmd_fifo.sv =====
module drbh_cmd_fifo
    import drbh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_en,
    input  drbh_cmd_t wr_cmd,
    output logic      full,
    input  logic      rd_en,
    output logic      rd_valid,
    output drbh_cmd_t rd_cmd
);

    drbh_cmd_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_cmd   = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (rd_en) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 2'd1;
        end else if (!wr_en && rd_en) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && full)) else $error("command queue written while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && !rd_valid)) else $error("command queue read while empty");

endmodule

// ===== rtl/drbh_engine.sv =====
module drbh_engine
    import drbh_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS,
    parameter int RING_DEPTH  = DEF_RING_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cmd_valid,
    input  drbh_cmd_t       cmd,
    output logic            cmd_pop,
    input  logic [CL_W-1:0] n_clients,
    input  logic [15:0]     frame_limit,
    output logic            out_valid,
    input  logic            out_ready,
    output drbh_res_t       out_res
);

    localparam int RING_CNT  = MAX_CLIENTS * 4;
    localparam int RW        = $clog2(RING_CNT);
    localparam int SLW       = $clog2(RING_DEPTH);
    localparam int MEM_DEPTH = RING_CNT * RING_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_OP      = 4'd1;
    localparam logic [3:0] S_RD      = 4'd2;
    localparam logic [3:0] S_SCAN    = 4'd3;
    localparam logic [3:0] S_TXRD    = 4'd4;
    localparam logic [3:0] S_DEST    = 4'd5;
    localparam logic [3:0] S_FREE_RD = 4'd6;
    localparam logic [3:0] S_FILL    = 4'd7;
    localparam logic [3:0] S_REFREE  = 4'd8;
    localparam logic [3:0] S_TXDONE  = 4'd9;
    localparam logic [3:0] S_EMIT    = 4'd10;

    logic [3:0]      state_reg, state_next;
    logic [3:0]      ret_reg, ret_next;
    drbh_cmd_t       cmd_reg, cmd_next;
    logic [CL_W-1:0] s_reg, s_next;
    logic [CL_W-1:0] d_reg, d_next;
    logic [31:0]     txo_reg, txo_next;
    logic [15:0]     txl_reg, txl_next;
    logic [31:0]     rxo_reg, rxo_next;
    logic            any_reg, any_next;
    drbh_res_t       res_reg, res_next;
    drbh_res_t       out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic [CNT_W-1:0] head_reg  [RING_CNT];
    logic [CNT_W-1:0] tail_reg  [RING_CNT];
    logic [SLW-1:0]   hslot_reg [RING_CNT];
    logic [SLW-1:0]   tslot_reg [RING_CNT];
    logic [47:0]      mem [MEM_DEPTH];
    logic [47:0]      rd_data_reg;

    logic [RW-1:0]    ring_sel;
    logic             do_push, do_pop;
    logic [47:0]      wr_data;
    logic [CNT_W-1:0] fill;
    logic             ring_full, ring_empty;
    logic [AW-1:0]    mem_addr;
    logic             out_free;
    logic [CL_W-1:0]  cl4;
    logic [CL_W:0]    d_inc, d_after;
    logic             is_last;
    logic [15:0]      cp;

    function automatic logic [RW-1:0] ring_of(input logic [CL_W-1:0] c, input logic [1:0] k);
        logic [CL_W+1:0] idx;
        idx = {c, k};
        return idx[RW-1:0];
    endfunction

    function automatic logic [SLW-1:0] slot_step(input logic [CNT_W-1:0] c,
                                                 input logic [SLW-1:0] s);
        logic [SLW-1:0] r;
        if (c == {CNT_W{1'b1}}) begin
            r = '0;
        end else if (s == SLW'(RING_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = s + SLW'(1);
        end
        return r;
    endfunction

    assign fill       = tail_reg[ring_sel] - head_reg[ring_sel];
    assign ring_full  = (fill >= CNT_W'(RING_DEPTH));
    assign ring_empty = (fill == '0);
    assign mem_addr   = AW'(ring_sel) * AW'(RING_DEPTH) +
                        AW'(do_push ? tslot_reg[ring_sel] : hslot_reg[ring_sel]);
    assign out_free   = !out_valid_reg || out_ready;
    assign cl4        = {1'b0, cmd_reg.client};
    assign d_inc      = {1'b0, d_reg} + 1'b1;
    assign d_after    = (d_inc == {1'b0, s_reg}) ? d_inc + 1'b1 : d_inc;
    assign is_last    = (n_clients == CL_W'(1)) || (d_after >= {1'b0, n_clients});
    assign cp         = (txl_reg < frame_limit) ? txl_reg : frame_limit;

    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        cmd_next       = cmd_reg;
        s_next         = s_reg;
        d_next         = d_reg;
        txo_next       = txo_reg;
        txl_next       = txl_reg;
        rxo_next       = rxo_reg;
        any_next       = any_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd_pop        = 1'b0;
        ring_sel       = '0;
        do_push        = 1'b0;
        do_pop         = 1'b0;
        wr_data        = '0;

        case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    state_next = S_OP;
                end
            end
            S_OP: begin
                res_next      = '0;
                res_next.last = 1'b1;
                ret_next      = S_IDLE;
                state_next    = S_EMIT;
                case (cmd_reg.kind)
                    KIND_POST_TX: begin
                        ring_sel = ring_of(cl4, RK_TX_PEND);
                        wr_data  = {cmd_reg.length, cmd_reg.offset};
                        do_push  = !ring_full;
                        res_next.status = ring_full ? ST_FULL : ST_OK;
                    end
                    KIND_GIVE_RX: begin
                        ring_sel = ring_of(cl4, RK_RX_FREE);
                        wr_data  = {16'd0, cmd_reg.offset};
                        do_push  = !ring_full;
                        res_next.status = ring_full ? ST_FULL : ST_OK;
                    end
                    KIND_TAKE_RX, KIND_TAKE_TXD: begin
                        ring_sel = (cmd_reg.kind == KIND_TAKE_RX) ?
                                   ring_of(cl4, RK_RX_FILL) : ring_of(cl4, RK_TX_DONE);
                        if (ring_empty) begin
                            res_next.status = ST_EMPTY;
                        end else begin
                            do_pop     = 1'b1;
                            state_next = S_RD;
                        end
                    end
                    KIND_FORWARD: begin
                        s_next     = '0;
                        any_next   = 1'b0;
                        state_next = S_SCAN;
                    end
                    default: begin
                        res_next.status = ST_BADCL;
                    end
                endcase
            end
            S_RD: begin
                res_next.status = ST_OK;
                if (cmd_reg.kind == KIND_TAKE_RX) begin
                    res_next.doff = rd_data_reg[31:0];
                    res_next.len  = rd_data_reg[47:32];
                end else begin
                    res_next.soff = rd_data_reg[31:0];
                end
                state_next = S_EMIT;
            end
            S_SCAN: begin
                // walk clients from the lowest for a pending tx frame
                ring_sel = ring_of(s_reg, RK_TX_PEND);
                if (s_reg >= n_clients) begin
                    res_next.status = ST_NOPEND;
                    state_next      = S_EMIT;
                end else if (!ring_empty) begin
                    do_pop     = 1'b1;
                    state_next = S_TXRD;
                end else begin
                    s_next = s_reg + 1'b1;
                end
            end
            S_TXRD: begin
                txo_next = rd_data_reg[31:0];
                txl_next = rd_data_reg[47:32];
                if (n_clients == CL_W'(1)) begin
                    d_next = s_reg;
                end else begin
                    d_next = (s_reg == '0) ? CL_W'(1) : '0;
                end
                state_next = S_DEST;
            end
            S_DEST: begin
                ring_sel      = ring_of(d_reg, RK_RX_FREE);
                res_next      = '0;
                res_next.src  = s_reg[2:0];
                res_next.dst  = d_reg[2:0];
                res_next.soff = txo_reg;
                res_next.last = is_last;
                if (ring_empty) begin
                    res_next.status = ST_NORX;
                    res_next.any    = is_last && any_reg;
                    ret_next        = is_last ? S_TXDONE : S_DEST;
                    d_next          = d_after[CL_W-1:0];
                    state_next      = S_EMIT;
                end else begin
                    do_pop     = 1'b1;
                    state_next = S_FREE_RD;
                end
            end
            S_FREE_RD: begin
                rxo_next   = rd_data_reg[31:0];
                state_next = S_FILL;
            end
            S_FILL: begin
                ring_sel     = ring_of(d_reg, RK_RX_FILL);
                wr_data      = {cp, rxo_reg};
                res_next.doff = rxo_reg;
                res_next.len  = cp;
                if (!ring_full) begin
                    do_push         = 1'b1;
                    any_next        = 1'b1;
                    res_next.status = ST_OK;
                    res_next.any    = is_last;
                    ret_next        = is_last ? S_TXDONE : S_DEST;
                    d_next          = d_after[CL_W-1:0];
                    state_next      = S_EMIT;
                end else begin
                    state_next = S_REFREE;
                end
            end
            S_REFREE: begin
                // hand the buffer back to the free ring with length zero
                ring_sel        = ring_of(d_reg, RK_RX_FREE);
                wr_data         = {16'd0, rxo_reg};
                do_push         = !ring_full;
                res_next.status = ST_RXFULL;
                res_next.any    = is_last && any_reg;
                ret_next        = is_last ? S_TXDONE : S_DEST;
                d_next          = d_after[CL_W-1:0];
                state_next      = S_EMIT;
            end
            S_TXDONE: begin
                ring_sel   = ring_of(s_reg, RK_TX_DONE);
                wr_data    = {16'd0, txo_reg};
                do_push    = !ring_full;
                state_next = S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RING_CNT; i++) begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                hslot_reg[i] <= '0;
                tslot_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (do_push) begin
                tail_reg[ring_sel]  <= tail_reg[ring_sel] + 1'b1;
                tslot_reg[ring_sel] <= slot_step(tail_reg[ring_sel], tslot_reg[ring_sel]);
            end
            if (do_pop) begin
                head_reg[ring_sel]  <= head_reg[ring_sel] + 1'b1;
                hslot_reg[ring_sel] <= slot_step(head_reg[ring_sel], hslot_reg[ring_sel]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        ret_reg <= ret_next;
        cmd_reg <= cmd_next;
        s_reg   <= s_next;
        d_reg   <= d_next;
        txo_reg <= txo_next;
        txl_reg <= txl_next;
        rxo_reg <= rxo_next;
        any_reg <= any_next;
        res_reg <= res_next;
        out_reg <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[mem_addr] <= wr_data;
        end
        rd_data_reg <= mem[mem_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |-> !ring_full) else $error("push into a full ring");
    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop |-> !ring_empty) else $error("pop from an empty ring");
    a_one_access: assert property (@(posedge aclk) disable iff (!aresetn)
        !(do_push && do_pop)) else $error("push and pop in one cycle");
    a_emit_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT && out_free) |=> out_valid_reg)
        else $error("result not loaded into output register");

endmodule

// ===== rtl/descriptor_ring_broadcast_hub.sv =====
// Descriptor-ring broadcast hub.
// Input channel s_*: one word carries an operation (post tx, give rx buffer,
// take rx, take tx done, forward one) with client, buffer offset and length.
// Result channel m_*: one or more words per defined operation; m_last marks the
// final word. A forward gives a word per destination client (active - 1, min 1).
// Configuration channel cfg_*: index 0 active client count, index 1 frame
// limit; write only while the hub is idle.
// Sequence: post and give push to the ring; take pops the ring and waits for
// the ring memory read. A forward scans clients for a pending frame, reads it,
// then per destination pops the rx free ring, reads the buffer, pushes the rx
// filled ring (or returns the buffer to free when that is full) and emits a
// word, or emits at once with no rx buffer; a tx done push ends it. The ring
// memory is single-port with a registered read.
// A two-entry command queue sits between the input classifier and the ring
// engine, so the hub keeps taking words, up to the queue depth, while the
// engine works or the receiver stalls, which holds the engine at its next result.
// Reset (aresetn low, synchronous) empties every ring and the queue, sets
// active clients to zero and the frame limit to 2048.
module descriptor_ring_broadcast_hub
    import drbh_pkg::*;
#(
    parameter int MAX_CLIENTS = DEF_MAX_CLIENTS,
    parameter int RING_DEPTH  = DEF_RING_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    input  logic [2:0]           s_client,
    input  logic [31:0]          s_buffer_offset,
    input  logic [15:0]          s_frame_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [2:0]           m_source_client,
    output logic [2:0]           m_dest_client,
    output logic [31:0]          m_source_offset,
    output logic [31:0]          m_dest_offset,
    output logic [15:0]          m_copy_length,
    output logic                 m_any_delivered,
    output logic                 m_last
);

    logic [CL_W-1:0] active_reg;
    logic [15:0]     limit_reg;
    logic [CL_W-1:0] n_clients;
    logic            q_full, q_wr, q_valid, q_pop;
    drbh_cmd_t       q_wcmd, q_rcmd;
    drbh_res_t       res;

    assign cfg_ready = 1'b1;

    // hold the configuration; to be written only while idle, which the hub does not enforce
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            limit_reg  <= 16'd2048;
        end else if (cfg_valid) begin
            if (cfg_index == CFG_ACTIVE) begin
                active_reg <= cfg_data[CL_W-1:0];
            end else if (cfg_index == CFG_LIMIT) begin
                limit_reg <= cfg_data;
            end
        end
    end

    // clip the client count to what the rings were built for
    assign n_clients = ({1'b0, active_reg} > (CL_W + 1)'(MAX_CLIENTS)) ?
                       CL_W'(MAX_CLIENTS) : active_reg;

    drbh_front u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_client        (s_client),
        .s_buffer_offset (s_buffer_offset),
        .s_frame_length  (s_frame_length),
        .n_clients       (n_clients),
        .q_full          (q_full),
        .q_wr            (q_wr),
        .q_cmd           (q_wcmd)
    );

    drbh_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (q_wr),
        .wr_cmd   (q_wcmd),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_cmd   (q_rcmd)
    );

    drbh_engine #(
        .MAX_CLIENTS (MAX_CLIENTS),
        .RING_DEPTH  (RING_DEPTH)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (q_valid),
        .cmd         (q_rcmd),
        .cmd_pop     (q_pop),
        .n_clients   (n_clients),
        .frame_limit (limit_reg),
        .out_valid   (m_valid),
        .out_ready   (m_ready),
        .out_res     (res)
    );

    assign m_status        = res.status;
    assign m_source_client = res.src;
    assign m_dest_client   = res.dst;
    assign m_source_offset = res.soff;
    assign m_dest_offset   = res.doff;
    assign m_copy_length   = res.len;
    assign m_any_delivered = res.any;
    assign m_last          = res.last;

endmodule
